FILE: rtl/pip_pkg.sv
package pip_pkg;

    localparam int MAX_CORNERS = 16;
    localparam int IDX_W       = $clog2(MAX_CORNERS);
    localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
    localparam int COUNT_W     = 5;
    localparam int INDEX_W     = 4;
    localparam int LAT_W       = 25;
    localparam int LON_W       = 26;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    typedef logic signed [LAT_W-1:0] lat_t;
    typedef logic signed [LON_W-1:0] lon_t;

    typedef struct packed {
        lat_t lat;
        lon_t lon;
    } corner_t;

    localparam int CORNER_W = $bits(corner_t);

    typedef struct packed {
        logic valid;
        logic in_poly;
    } pip_done_t;

    // On a straddling edge the truncated quotient (lat - lat_i) / (lat_j - lat_i)
    // is 1 only when lat_i lies south and lat_j equals lat, otherwise 0, so
    // the crossing longitude is one of the two end longitudes.
    function automatic logic edge_toggle(lat_t lat, lon_t lon, corner_t ci, corner_t cj);
        logic si;
        logic sj;
        logic west;
        lon_t x;
        si   = ci.lat < lat;
        sj   = cj.lat < lat;
        west = (ci.lon <= lon) || (cj.lon <= lon);
        x    = (si && (cj.lat == lat)) ? cj.lon : ci.lon;
        return (si ^ sj) && west && (x < lon);
    endfunction

endpackage

FILE: rtl/pip_if.sv
interface pip_item_if import pip_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [INDEX_W-1:0]   index;
    lat_t                 latitude;
    lon_t                 longitude;

    modport source (output valid, output operation, output index, output latitude,
                    output longitude, input ready);
    modport sink   (input valid, input operation, input index, input latitude,
                    input longitude, output ready);
endinterface

interface pip_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

FILE: rtl/pip_ram.sv
module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pip_walk.sv
module pip_walk import pip_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] n,
    input  lat_t             lat,
    input  lon_t             lon,
    output logic             idle,
    output logic [IDX_W-1:0] raddr,
    input  corner_t          rdata,
    input  logic             out_free,
    output pip_done_t        done
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LAST = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    corner_t          prev_reg, prev_next;
    lat_t             lat_reg, lat_next;
    lon_t             lon_reg, lon_next;
    logic             acc_reg, acc_next;

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        prev_next    = prev_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        acc_next     = acc_reg;
        raddr        = ptr_reg[IDX_W-1:0];
        done.valid   = 1'b0;
        done.in_poly = acc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // first edge closes the ring: fetch the last corner
                raddr = IDX_W'(n - 1'b1);
                if (start)
                begin
                    lat_next   = lat;
                    lon_next   = lon;
                    acc_next   = 1'b0;
                    ptr_next   = '0;
                    state_next = (n == '0) ? S_DONE : S_LAST;
                end
            end
            S_LAST:
            begin
                prev_next  = rdata;
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                acc_next  = acc_reg ^ edge_toggle(lat_reg, lon_reg, rdata, prev_reg);
                prev_next = rdata;
                if (ptr_reg == n)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                done.valid = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        lat_reg  <= lat_next;
        lon_reg  <= lon_next;
    end

    assign idle = (state_reg == S_IDLE);

endmodule

FILE: rtl/point_in_polygon_fixed_top.sv
// Write transfer: stored in the corner memory at the accepting edge, no result.
// Test transfer: result registered after the walk over the n stored edges,
// n = min(corner_count, 16); one corner memory read per edge.
// Throughput: one write per cycle when idle; a test holds off new items until
// its result is taken into the output register.
// Reset: asynchronous active low; clears corner_count, control and result
// valid; corner memory contents are not reset.
module point_in_polygon_fixed_top import pip_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    pip_item_if.sink            item,
    pip_result_if.source        result
);

    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    logic               inside_reg;
    logic [CNT_W-1:0]   n_sat;
    logic               accept;
    logic               ram_we;
    logic               idle;
    logic               out_free;
    logic [IDX_W-1:0]   raddr;
    corner_t            wcorner;
    corner_t            rcorner;
    pip_done_t          done;

    always_comb
    begin
        if (int'(count_reg) > MAX_CORNERS)
        begin
            n_sat = CNT_W'(MAX_CORNERS);
        end
        else
        begin
            n_sat = CNT_W'(count_reg);
        end
    end

    assign item.ready = idle;
    assign accept     = item.valid && item.ready;
    assign ram_we     = accept && (item.operation == OP_WRITE)
                        && (int'(item.index) < MAX_CORNERS);
    assign wcorner    = '{lat: item.latitude, lon: item.longitude};
    assign out_free   = !out_valid_reg || result.ready;

    pip_ram #(
        .WIDTH (CORNER_W),
        .DEPTH (MAX_CORNERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(item.index)),
        .wdata (wcorner),
        .raddr (raddr),
        .rdata (rcorner)
    );

    pip_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (item.operation == OP_TEST)),
        .n        (n_sat),
        .lat      (item.latitude),
        .lon      (item.longitude),
        .idle     (idle),
        .raddr    (raddr),
        .rdata    (rcorner),
        .out_free (out_free),
        .done     (done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (done.valid && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.valid && out_free)
        begin
            inside_reg <= done.in_poly;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.inside_res = inside_reg;

endmodule

FILE: rtl/pip_check.sv
module pip_check import pip_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_operation,
    input logic out_valid,
    input logic out_ready,
    input logic out_inside
);

    // a test transfer makes the block busy
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_TEST) |=> !in_ready)
        else $error("input ready after test transfer");

    // a result appears only at the end of a busy walk
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without preceding walk");

    // a write never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_WRITE) && !out_valid |=> !out_valid)
        else $error("result after write transfer");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_inside))
        else $error("stalled result changed");

endmodule

bind point_in_polygon_fixed_top pip_check u_pip_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .in_operation (item.operation),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_inside   (result.inside_res)
);

FILE: sim/tb_point_in_polygon_fixed_top.sv
module tb_point_in_polygon_fixed_top import pip_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [COUNT_W-1:0]  cfg_wdata;

    pip_item_if   item_bus ();
    pip_result_if result_bus ();

    point_in_polygon_fixed_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_bus),
        .result    (result_bus)
    );

    // predictor state
    longint              lat_mem [MAX_CORNERS];
    longint              lon_mem [MAX_CORNERS];
    bit [MAX_CORNERS-1:0] written;
    logic [COUNT_W-1:0]  count_reg;
    bit                  exp_inside_q [$];

    int                  fail_count;
    int                  items_sent;
    bit                  idle_en;
    int                  stall_req;

    // current polygon neighborhood for random stimulus
    longint              lat_c;
    longint              lon_c;
    longint              radius;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit predict_inside(longint lat, longint lon);
        int     n;
        int     j;
        bit     in_poly;
        longint lai;
        longint laj;
        longint loi;
        longint loj;
        longint q;
        longint x;
        n = (count_reg > MAX_CORNERS) ? MAX_CORNERS : int'(count_reg);
        in_poly = 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            lai = lat_mem[i];
            laj = lat_mem[j];
            loi = lon_mem[i];
            loj = lon_mem[j];
            if (((lai < lat && laj >= lat) || (laj < lat && lai >= lat)) &&
                (loi <= lon || loj <= lon))
            begin
                // truncating divide first, then scale
                q = (lat - lai) / (laj - lai);
                x = loi + q * (loj - loi);
                if (x < lon)
                    in_poly = ~in_poly;
            end
            j = i;
        end
        return in_poly;
    endfunction

    function automatic longint jitter(longint c, longint r);
        return c + longint'($urandom_range(0, 2 * r)) - r;
    endfunction

    task automatic send_item(logic op, logic [INDEX_W-1:0] idx, lat_t lat, lon_t lon);
        if (idle_en && $urandom_range(99) < 12)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.operation <= op;
        item_bus.index     <= idx;
        item_bus.latitude  <= lat;
        item_bus.longitude <= lon;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        if (op == OP_WRITE)
        begin
            lat_mem[idx] = longint'(lat);
            lon_mem[idx] = longint'(lon);
            written[idx] = 1'b1;
        end
        else
        begin
            exp_inside_q.push_back(predict_inside(longint'(lat), longint'(lon)));
        end
        items_sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        item_bus.valid <= 1'b0;
        while (exp_inside_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (exp_inside_q.size() != 0)
        begin
            $error("inside_res: %0d results never arrived", exp_inside_q.size());
            fail_count++;
            exp_inside_q.delete();
        end
        repeat (24) @(posedge clk);
    endtask

    task automatic write_corner_count(logic [COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_reg = value;
    endtask

    task automatic send_random_corner(int idx);
        lat_t lat;
        lon_t lon;
        if ($urandom_range(99) < 8)
        begin
            lat = lat_t'($urandom);
            lon = lon_t'($urandom);
        end
        else
        begin
            // shared latitudes give horizontal edges
            if (idx > 0 && $urandom_range(4) == 0)
                lat = lat_t'(lat_mem[idx-1]);
            else
                lat = lat_t'(jitter(lat_c, radius));
            lon = lon_t'(jitter(lon_c, radius));
        end
        send_item(OP_WRITE, idx[INDEX_W-1:0], lat, lon);
    endtask

    task automatic send_random_query(int n);
        lat_t                lat;
        lon_t                lon;
        logic [INDEX_W-1:0]  idx;
        idx = INDEX_W'($urandom);
        if ($urandom_range(19) == 0)
        begin
            lat = lat_t'($urandom);
            lon = lon_t'($urandom);
        end
        else
        begin
            if (n > 0 && $urandom_range(3) == 0)
                lat = lat_t'(lat_mem[$urandom_range(n - 1)]);
            else
                lat = lat_t'(jitter(lat_c, radius + radius / 4));
            if (n > 0 && $urandom_range(6) == 0)
                lon = lon_t'(lon_mem[$urandom_range(n - 1)]);
            else
                lon = lon_t'(jitter(lon_c, radius + radius / 4));
        end
        send_item(OP_TEST, idx, lat, lon);
    endtask

    task automatic ensure_written(int n);
        for (int i = 0; i < n; i++)
            if (!written[i])
                send_random_corner(i);
    endtask

    task automatic test_empty_polygon();
        send_item(OP_TEST, 4'd0, lat_t'(0), lon_t'(0));
        send_item(OP_TEST, 4'd15, lat_t'(-9000000), lon_t'(18000000));
        drain_results();
    endtask

    task automatic test_square();
        write_corner_count(5'd4);
        send_item(OP_WRITE, 4'd0, lat_t'(-100000), lon_t'(-100000));
        send_item(OP_WRITE, 4'd1, lat_t'(-100000), lon_t'(100000));
        send_item(OP_WRITE, 4'd2, lat_t'(100000), lon_t'(100000));
        send_item(OP_WRITE, 4'd3, lat_t'(100000), lon_t'(-100000));
        send_item(OP_TEST, 4'd0, lat_t'(0), lon_t'(0));
        send_item(OP_TEST, 4'd1, lat_t'(0), lon_t'(200000));
        send_item(OP_TEST, 4'd2, lat_t'(-100000), lon_t'(0));
        send_item(OP_TEST, 4'd3, lat_t'(100000), lon_t'(0));
        send_item(OP_TEST, 4'd4, lat_t'(100000), lon_t'(200000));
        send_item(OP_TEST, 4'd5, lat_t'(0), lon_t'(-100000));
        send_item(OP_TEST, 4'd6, {1'b1, {(LAT_W-1){1'b0}}}, {1'b0, {(LON_W-1){1'b1}}});
        send_item(OP_TEST, 4'd7, {1'b0, {(LAT_W-1){1'b1}}}, {1'b1, {(LON_W-1){1'b0}}});
        drain_results();
    endtask

    task automatic test_field_extremes();
        write_corner_count(5'd3);
        send_item(OP_WRITE, 4'd0, {1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}});
        send_item(OP_WRITE, 4'd1, {1'b0, {(LAT_W-1){1'b1}}}, lon_t'(0));
        send_item(OP_WRITE, 4'd2, lat_t'(0), {1'b0, {(LON_W-1){1'b1}}});
        send_item(OP_TEST, 4'd0, lat_t'(0), lon_t'(0));
        send_item(OP_TEST, 4'd8, lat_t'(-1), lon_t'(-1));
        send_item(OP_TEST, 4'd15, {1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}});
        send_item(OP_TEST, 4'd9, lat_t'(9000000), lon_t'(-18000000));
        drain_results();
    endtask

    task automatic test_random_polygons();
        int cnt;
        int n;
        for (int phase = 0; phase < 20; phase++)
        begin
            drain_results();
            idle_en = (phase != 7);
            if ($urandom_range(9) == 0)
                cnt = int'($urandom_range(17, 31));
            else
                cnt = int'($urandom_range(0, MAX_CORNERS));
            n = (cnt > MAX_CORNERS) ? MAX_CORNERS : cnt;
            lat_c  = longint'($urandom_range(0, 18000000)) - 9000000;
            lon_c  = longint'($urandom_range(0, 36000000)) - 18000000;
            radius = $urandom_range(1) ? longint'($urandom_range(4, 2000))
                                       : longint'($urandom_range(2000, 3000000));
            write_corner_count(cnt[COUNT_W-1:0]);
            for (int i = 0; i < n; i++)
                send_random_corner(i);
            for (int k = 0; k < 40; k++)
            begin
                if ($urandom_range(99) < 15)
                    send_random_corner($urandom_range(MAX_CORNERS - 1));
                else
                    send_random_query(n);
            end
        end
        idle_en = 1'b1;
        drain_results();
    endtask

    task automatic test_count_saturation();
        ensure_written(MAX_CORNERS);
        drain_results();
        write_corner_count(5'd31);
        send_random_query(MAX_CORNERS);
        send_random_query(MAX_CORNERS);
        drain_results();
        write_corner_count(5'd17);
        send_random_query(MAX_CORNERS);
        send_random_query(MAX_CORNERS);
        drain_results();
        write_corner_count(5'd16);
        send_random_query(MAX_CORNERS);
        drain_results();
    endtask

    task automatic test_backpressure();
        ensure_written(MAX_CORNERS);
        drain_results();
        write_corner_count(5'd16);
        stall_req = 400;
        for (int k = 0; k < 40; k++)
            send_random_query(MAX_CORNERS);
        drain_results();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.operation <= OP_WRITE;
        item_bus.index     <= '0;
        item_bus.latitude  <= '0;
        item_bus.longitude <= '0;
        idle_en    = 1'b1;
        count_reg  = '0;
        written    = '0;
        fail_count = 0;
        items_sent = 0;
        stall_req  = 0;
        lat_c      = 0;
        lon_c      = 0;
        radius     = 1000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_polygon();
        test_square();
        test_field_extremes();
        test_random_polygons();
        test_count_saturation();
        test_backpressure();

        drain_results();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result sink: random idling plus requested long hold-offs
    initial
    begin
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_req > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall_req) @(posedge clk);
                stall_req = 0;
            end
            result_bus.ready <= idle_en ? ($urandom_range(99) >= 12) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (exp_inside_q.size() == 0)
            begin
                $error("inside_res: unexpected transfer, actual %0b", result_bus.inside_res);
                fail_count++;
            end
            else
            begin
                if (result_bus.inside_res !== exp_inside_q[0])
                begin
                    $error("inside_res: expected %0b, actual %0b",
                           exp_inside_q[0], result_bus.inside_res);
                    fail_count++;
                end
                void'(exp_inside_q.pop_front());
            end
        end
    end

endmodule

FILE: sim.f
rtl/pip_pkg.sv
rtl/pip_if.sv
rtl/pip_ram.sv
rtl/pip_walk.sv
rtl/point_in_polygon_fixed_top.sv
rtl/pip_check.sv
sim/tb_point_in_polygon_fixed_top.sv
